// ===== src/baa_pkg.sv =====
`timescale 1ns / 1ps

package baa_pkg;

    // arena geometry
    localparam int unsigned ALIGNMENT    = 8;
    localparam int unsigned COMMIT_CHUNK = 4096;

    localparam logic [31:0] DEFAULT_CAPACITY = 32'd1048576;
    // largest aligned capacity that still fits 32 bits
    localparam logic [31:0] MAX_CAPACITY =
        32'((64'h0000_0000_FFFF_FFFF / 64'(ALIGNMENT)) * 64'(ALIGNMENT));

    // operation codes
    localparam logic [2:0] OP_ALLOC        = 3'd0;
    localparam logic [2:0] OP_REALLOC      = 3'd1;
    localparam logic [2:0] OP_RELEASE_TO   = 3'd2;
    localparam logic [2:0] OP_RELEASE_SIZE = 3'd3;
    localparam logic [2:0] OP_CLEAR        = 3'd4;
    localparam logic [2:0] OP_QUERY        = 3'd5;

    // register indexes on the configuration port
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_PRESENT  = 1'b1;

    localparam int unsigned APB_ADDR_W = 3;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic eval;
        logic finish;
    } baa_cmd_t;

    function automatic logic [33:0] align_up(input logic [33:0] x);
        return (x + 34'(ALIGNMENT - 1)) / 34'(ALIGNMENT) * 34'(ALIGNMENT);
    endfunction

    function automatic logic [33:0] chunk_up(input logic [33:0] x);
        return (x + 34'(COMMIT_CHUNK - 1)) / 34'(COMMIT_CHUNK) * 34'(COMMIT_CHUNK);
    endfunction

endpackage

// ===== src/baa_if.sv =====
`timescale 1ns / 1ps

interface baa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] request_size;
    logic [31:0] block_offset;
    logic        has_block;

    modport source (
        output valid, operation, request_size, block_offset, has_block,
        input  ready
    );
    modport sink (
        input  valid, operation, request_size, block_offset, has_block,
        output ready
    );
endinterface

interface baa_rsp_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic [31:0] result_offset;
    logic [31:0] current_level;
    logic        commit_valid;
    logic [31:0] commit_offset;
    logic [31:0] commit_length;

    modport source (
        output valid, success, result_offset, current_level,
               commit_valid, commit_offset, commit_length,
        input  ready
    );
    modport sink (
        input  valid, success, result_offset, current_level,
               commit_valid, commit_offset, commit_length,
        output ready
    );
endinterface

// ===== src/baa_cfg_regs.sv =====
`timescale 1ns / 1ps

module baa_cfg_regs
    import baa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [31:0]           capacity,
    output logic                  present
);

    logic [31:0] capacity_reg;
    logic [31:0] capacity_next;
    logic        present_reg;
    logic        present_next;
    logic        wr_en;
    logic [33:0] cap_aligned;

    assign pready      = 1'b1;
    assign wr_en       = psel & penable & pwrite;
    assign cap_aligned = align_up({2'b00, pwdata});

    always_comb
    begin
        capacity_next = capacity_reg;
        present_next  = present_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_CAPACITY:
                begin
                    if (pwdata == 32'd0)
                        capacity_next = DEFAULT_CAPACITY;
                    else if (cap_aligned[33:32] != 2'b00)
                        capacity_next = MAX_CAPACITY;
                    else
                        capacity_next = cap_aligned[31:0];
                end
                REG_PRESENT:
                    present_next = pwdata[0];
                default:
                    present_next = present_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= DEFAULT_CAPACITY;
            present_reg  <= 1'b1;
        end
        else
        begin
            capacity_reg <= capacity_next;
            present_reg  <= present_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CAPACITY: prdata = capacity_reg;
            REG_PRESENT:  prdata = {31'd0, present_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign capacity = capacity_reg;
    assign present  = present_reg;

endmodule

// ===== src/baa_ctrl.sv =====
`timescale 1ns / 1ps

module baa_ctrl
    import baa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output baa_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free    = !out_valid_reg || out_ready;
    assign cmd.finish  = (state_reg == ST_DONE) && out_free;
    assign cmd.eval    = (state_reg == ST_EVAL);
    assign in_ready    = (state_reg == ST_IDLE) || cmd.finish;
    assign cmd.load_in = in_valid && in_ready;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = cmd.load_in ? ST_EVAL : ST_IDLE;
            ST_EVAL: state_next = ST_DONE;
            ST_DONE:
            begin
                if (cmd.finish)
                    state_next = cmd.load_in ? ST_EVAL : ST_IDLE;
                else
                    state_next = ST_DONE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_eval_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |=> state_reg == ST_DONE)
        else $error("evaluation step not followed by completion step");

    a_load_enters_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == ST_EVAL)
        else $error("accepted item did not start evaluation");

    a_no_accept_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> !in_ready)
        else $error("item accepted while another is being evaluated");

    a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished item not presented");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && !out_free |=> state_reg == ST_DONE && out_valid_reg)
        else $error("completion left while result slot busy");
`endif

endmodule

// ===== src/baa_datapath.sv =====
`timescale 1ns / 1ps

module baa_datapath
    import baa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  baa_cmd_t    cmd,
    input  logic [2:0]  operation,
    input  logic [31:0] request_size,
    input  logic [31:0] block_offset,
    input  logic        has_block,
    input  logic [31:0] capacity,
    input  logic        present,
    output logic        success,
    output logic [31:0] result_offset,
    output logic [31:0] current_level,
    output logic        commit_valid,
    output logic [31:0] commit_offset,
    output logic [31:0] commit_length
);

    // accepted item
    logic [2:0]  op_reg;
    logic [31:0] size_reg;
    logic [31:0] pos_reg;
    logic        has_reg;

    // arena state
    logic [31:0] level_reg;
    logic [31:0] level_next;
    logic [31:0] committed_reg;
    logic [31:0] committed_next;

    // evaluation stage results
    logic        a_alloc_reg;
    logic [31:0] a_where_reg;
    logic [31:0] a_lvl_reg;
    logic [31:0] a_arg_reg;
    logic        a_ok_reg;
    logic [31:0] a_level_reg;
    logic [31:0] a_room_reg;

    logic        a_alloc;
    logic [31:0] a_where;
    logic [31:0] a_arg;
    logic        a_ok;
    logic [31:0] a_level;

    logic [33:0] lvl_al34;
    logic [31:0] lvl_al;
    logic [32:0] sum33;
    logic [32:0] grow_arg33;
    logic        pos_below;
    logic        grows;
    logic        past_pad;

    // completion stage
    logic [33:0] sz34;
    logic [33:0] top34;
    logic [33:0] take34;
    logic [31:0] take;
    logic        over_commit;
    logic        over_cap;
    logic        b_ok;
    logic [31:0] b_where;
    logic        b_cvalid;
    logic [31:0] b_coff;
    logic [31:0] b_clen;

    // result register
    logic        success_reg;
    logic [31:0] result_offset_reg;
    logic [31:0] current_level_reg;
    logic        commit_valid_reg;
    logic [31:0] commit_offset_reg;
    logic [31:0] commit_length_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= operation;
            size_reg <= request_size;
            pos_reg  <= block_offset;
            has_reg  <= has_block;
        end
    end

    // size + offset gives the new level for in-place reallocation and,
    // less the aligned level, the extra bytes a grow must allocate
    assign lvl_al34   = align_up({2'b00, level_reg});
    assign lvl_al     = lvl_al34[31:0];
    assign sum33      = {1'b0, size_reg} + {1'b0, pos_reg};
    assign grow_arg33 = sum33 - {1'b0, lvl_al};
    assign pos_below  = pos_reg < level_reg;
    assign grows      = sum33 > {1'b0, level_reg};
    assign past_pad   = sum33 > {1'b0, lvl_al};

    always_comb
    begin
        a_alloc = 1'b0;
        a_where = 32'd0;
        a_arg   = size_reg;
        a_ok    = 1'b0;
        a_level = level_reg;
        case (op_reg)
            OP_ALLOC:
            begin
                a_alloc = 1'b1;
                a_where = lvl_al;
            end
            OP_REALLOC:
            begin
                if (!has_reg)
                begin
                    a_alloc = 1'b1;
                    a_where = lvl_al;
                end
                else if (pos_below)
                begin
                    a_where = pos_reg;
                    if (grows && past_pad)
                    begin
                        a_alloc = 1'b1;
                        a_arg   = grow_arg33[31:0];
                    end
                    else
                    begin
                        a_ok    = 1'b1;
                        a_level = sum33[31:0];
                    end
                end
            end
            OP_RELEASE_TO:
            begin
                a_ok    = 1'b1;
                a_level = pos_below ? pos_reg : level_reg;
            end
            OP_RELEASE_SIZE:
            begin
                a_ok    = 1'b1;
                a_level = (size_reg < level_reg) ? (level_reg - size_reg) : 32'd0;
            end
            OP_CLEAR:
            begin
                a_ok    = 1'b1;
                a_level = 32'd0;
            end
            OP_QUERY:
                a_ok = 1'b1;
            default:
                a_ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_alloc_reg <= 1'b0;
            a_ok_reg    <= 1'b0;
        end
        else if (cmd.eval)
        begin
            a_alloc_reg <= a_alloc;
            a_ok_reg    <= a_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            a_where_reg <= a_where;
            a_lvl_reg   <= lvl_al;
            a_arg_reg   <= a_arg;
            a_level_reg <= a_level;
            a_room_reg  <= capacity - committed_reg;
        end
    end

    assign sz34        = align_up({2'b00, a_arg_reg});
    assign top34       = {2'b00, a_lvl_reg} + sz34;
    assign take34      = chunk_up(sz34);
    assign take        = (take34 > {2'b00, a_room_reg}) ? a_room_reg : take34[31:0];
    assign over_commit = top34 > {2'b00, committed_reg};
    assign over_cap    = top34 > {2'b00, capacity};

    always_comb
    begin
        b_ok           = a_ok_reg;
        b_where        = a_where_reg;
        level_next     = a_level_reg;
        committed_next = committed_reg;
        b_cvalid       = 1'b0;
        b_coff         = 32'd0;
        b_clen         = 32'd0;
        if (a_alloc_reg)
        begin
            if (!present)
            begin
                b_ok       = 1'b0;
                level_next = level_reg;
            end
            else if (over_commit && over_cap)
            begin
                // level keeps its aligned value on failure
                b_ok       = 1'b0;
                level_next = a_lvl_reg;
            end
            else
            begin
                b_ok       = 1'b1;
                level_next = top34[31:0];
                if (over_commit)
                begin
                    committed_next = committed_reg + take;
                    b_cvalid       = take != 32'd0;
                    b_coff         = b_cvalid ? committed_reg : 32'd0;
                    b_clen         = take;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 32'd0;
            committed_reg <= 32'd0;
        end
        else if (cmd.finish)
        begin
            level_reg     <= level_next;
            committed_reg <= committed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            success_reg       <= b_ok;
            result_offset_reg <= b_ok ? b_where : 32'd0;
            current_level_reg <= level_next;
            commit_valid_reg  <= b_cvalid;
            commit_offset_reg <= b_coff;
            commit_length_reg <= b_clen;
        end
    end

    assign success       = success_reg;
    assign result_offset = result_offset_reg;
    assign current_level = current_level_reg;
    assign commit_valid  = commit_valid_reg;
    assign commit_offset = commit_offset_reg;
    assign commit_length = commit_length_reg;

endmodule

// ===== src/bump_arena_allocator.sv =====
`timescale 1ns / 1ps

// Bump-pointer arena allocator on byte offsets. Each item on req carries an
// operation (allocate, reallocate, release to offset, release size, clear,
// query level) and gives exactly one item on rsp with success, block offset,
// the allocation level after the operation and, when an allocation pushes
// past the committed level, a commit request (offset and chunk-rounded length
// clamped to the capacity). An accepted item passes an evaluation step
// (alignment of the level, in-place reallocation checks, release
// arithmetic), then a completion step (aligned size add, capacity and
// commit compares, level update) that loads its result. A new item is
// accepted in the completion step once the result register is free, not in
// evaluation; the result register lets the next item start while a result
// still waits. Capacity and presence (APB, capacity at 0x0, presence at 0x4)
// must be written by the user only while the block is idle; it is unchecked.
module bump_arena_allocator
    import baa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    baa_req_if.sink               req,
    baa_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // control path to datapath commands
    baa_cmd_t    cmd;

    // configuration seen by the datapath
    logic [31:0] capacity;
    logic        present;

    // configuration registers, to be written only while idle (unchecked)
    baa_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity),
        .present  (present)
    );

    // sequencer: accept, evaluate, complete into the result register
    baa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // level and committed-level registers plus the two evaluation steps
    baa_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (req.operation),
        .request_size  (req.request_size),
        .block_offset  (req.block_offset),
        .has_block     (req.has_block),
        .capacity      (capacity),
        .present       (present),
        .success       (rsp.success),
        .result_offset (rsp.result_offset),
        .current_level (rsp.current_level),
        .commit_valid  (rsp.commit_valid),
        .commit_offset (rsp.commit_offset),
        .commit_length (rsp.commit_length)
    );

endmodule
